// ===== rtl/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock.
// No dependencies; every other file in this block depends on it.
package kcl_pkg;

	localparam int LINES_W = 16;
	localparam int KEY_W   = 5;

	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		VERDICT_NONE     = 2'd0,
		VERDICT_SAVED    = 2'd1,
		VERDICT_MATCH    = 2'd2,
		VERDICT_MISMATCH = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [LINES_W-1:0] key_lines;
	} in_beat_t;

	typedef struct packed {
		logic       new_press;
		key_t       key_code;
		logic [1:0] verdict;
		logic       code_stored;
	} out_beat_t;

endpackage

// ===== rtl/kcl_stream_if.sv =====
// Valid/ready stream interface used for the keypad code lock channels.
// Depends on kcl_pkg for the default payload type.
interface kcl_stream_if #(
	parameter type payload_t = kcl_pkg::in_beat_t
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/kcl_decode.sv =====
// Priority decoder from active-low keypad lines to a key number.
// Depends on kcl_pkg.
module kcl_decode #(
	parameter int NUM_KEYS = 16
) (
	input  logic [kcl_pkg::LINES_W-1:0] key_lines,
	output kcl_pkg::key_t               key
);
	import kcl_pkg::*;

	// The highest low line wins; lines at or above NUM_KEYS are ignored.
	always_comb begin
		key = '0;
		for (int i = 0; i < LINES_W; i++) begin
			if (i < NUM_KEYS && !key_lines[i]) begin
				key = KEY_W'(i + 1);
			end
		end
	end
endmodule

// ===== rtl/kcl_lock.sv =====
// Lock state: previous key, entry window, entry count, stored code and verdict.
// Depends on kcl_pkg.
module kcl_lock #(
	parameter int CODE_LEN = 10,
	parameter int NUM_KEYS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  kcl_pkg::key_t      key,
	output kcl_pkg::out_beat_t result
);
	import kcl_pkg::*;

	localparam int   CntW     = $clog2(CODE_LEN + 1);
	localparam key_t SaveKey  = KEY_W'(NUM_KEYS - 1);
	localparam key_t CheckKey = KEY_W'(NUM_KEYS);

	key_t                          last_key_q;
	logic [CODE_LEN-1:0][KEY_W-1:0] window_q;
	logic [CODE_LEN-1:0][KEY_W-1:0] saved_q;
	logic [CntW-1:0]               count_q;
	logic                          saved_flag_q;

	logic press, full, do_save, do_check, do_shift, same;

	always_comb begin
		press    = (key != last_key_q) && (key != '0);
		full     = (count_q == CntW'(CODE_LEN));
		do_save  = press && (key == SaveKey) && full && !saved_flag_q;
		do_check = press && (key == CheckKey) && full && saved_flag_q;
		do_shift = press && !do_save && !do_check;
		same     = (window_q == saved_q);

		result.new_press   = press;
		result.key_code    = key;
		result.code_stored = saved_flag_q | do_save;
		if (do_save) begin
			result.verdict = VERDICT_SAVED;
		end else if (do_check) begin
			result.verdict = same ? VERDICT_MATCH : VERDICT_MISMATCH;
		end else begin
			result.verdict = VERDICT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q   <= '0;
			window_q     <= '0;
			count_q      <= '0;
			saved_flag_q <= 1'b0;
		end else if (step) begin
			last_key_q <= key;
			if (do_save || do_check) begin
				window_q <= '0;
				count_q  <= '0;
			end else if (do_shift) begin
				for (int i = 0; i < CODE_LEN - 1; i++) begin
					window_q[i] <= window_q[i+1];
				end
				window_q[CODE_LEN-1] <= key;
				if (!full) begin
					count_q <= count_q + CntW'(1);
				end
			end
			if (do_save) begin
				saved_flag_q <= 1'b1;
			end
		end
	end

	// The stored code holds no reset value; it is read only after the save.
	always_ff @(posedge clk) begin
		if (step && do_save) begin
			saved_q <= window_q;
		end
	end
endmodule

// ===== rtl/kcl_out_queue.sv =====
// Two-entry result queue that decouples the lock from the result sink.
// Depends on kcl_pkg.
module kcl_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kcl_pkg::out_beat_t push_data,
	output logic               has_room,
	output logic               out_valid,
	input  logic               out_ready,
	output kcl_pkg::out_beat_t out_data
);
	import kcl_pkg::*;

	out_beat_t  entry_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign has_room  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = entry_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end
endmodule

// ===== rtl/keypad_code_lock_core.sv =====
// Top level of the keypad code lock: input register, decoder, lock state, result queue.
// Depends on kcl_pkg, kcl_stream_if, kcl_decode, kcl_lock and kcl_out_queue.
//
//   Channel   Role     Payload
//   keys      sink     key_lines: 16 active-low keypad lines, one sample per beat
//   result    source   new_press, key_code, verdict, code_stored, one per key beat
//
// Each sample lands in the input register; when the queue has room, the decoder
// and the lock update the state and write the result into a two-entry queue,
// so one sample per cycle is sustained while the sink takes.
// A result is valid on the result channel once it has been written into the queue.
// arst_n clears the window, count, last key, saved flag and all valid bits; the
// stored code itself is not cleared and is only read once a code has been saved.
// When the result sink stalls, the queue absorbs up to two results; ready on the
// keys side drops only when the input register holds a sample and the queue is full.
module keypad_code_lock_core #(
	parameter int CODE_LEN = 10,
	parameter int NUM_KEYS = 16
) (
	input logic         clk,
	input logic         arst_n,
	kcl_stream_if.sink   keys,
	kcl_stream_if.source result
);
	import kcl_pkg::*;

	// Input register stage.
	logic               v_s1;
	logic [LINES_W-1:0] key_lines_s1;

	logic      q_room;
	logic      fire_s1;
	key_t      key_s1;
	out_beat_t lock_result;
	out_beat_t out_data;
	logic      out_valid;

	// The sample in stage one moves on whenever the queue has space.
	assign fire_s1    = v_s1 && q_room;
	assign keys.ready = !v_s1 || q_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (keys.ready) begin
			v_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			key_lines_s1 <= keys.data.key_lines;
		end
	end

	kcl_decode #(
		.NUM_KEYS(NUM_KEYS)
	) u_decode (
		.key_lines(key_lines_s1),
		.key      (key_s1)
	);

	// State updates only when the sample's result is written to the queue.
	kcl_lock #(
		.CODE_LEN(CODE_LEN),
		.NUM_KEYS(NUM_KEYS)
	) u_lock (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (fire_s1),
		.key   (key_s1),
		.result(lock_result)
	);

	kcl_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire_s1),
		.push_data(lock_result),
		.has_room (q_room),
		.out_valid(out_valid),
		.out_ready(result.ready),
		.out_data (out_data)
	);

	assign result.valid = out_valid;
	assign result.data  = out_data;
endmodule
